/* hdl/d64_pkg.sv */
// Package for the 64-bit integer divider: operation codes and width constants.
// No dependencies.
package d64_pkg;
  localparam int DefDataWidth = 64;
  localparam int FieldWidth = 64;
  localparam logic [1:0] OP_UQUOT  = 2'd0;
  localparam logic [1:0] OP_UREM   = 2'd1;
  localparam logic [1:0] OP_SQUOT  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;
endpackage

/* hdl/div64_signed_unsigned.sv */
// Top level of the 64-bit integer divider: a pipeline with one restoring
// subtract stage per quotient bit. Depends on d64_pkg.
//
//   channel | handshake       | fields
//   in      | valid / ready   | operation, dividend, divisor
//   out     | out_valid/ready | result, divide_by_zero
//
// A word passes DATA_WIDTH + 2 register stages: one takes magnitudes, one per
// quotient bit does a trial subtract, one fixes the sign and selects. A new
// word can enter every cycle unless an output stall has filled the pipeline.
// Reset clears only the valid bits.
// A stall on the output freezes every stage that holds a word behind it;
// empty stages still move up, so bubbles are squeezed out.
module div64_signed_unsigned #(
  parameter int DATA_WIDTH = d64_pkg::DefDataWidth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  output logic                           ready,
  input  logic [1:0]                     operation,
  input  logic [d64_pkg::FieldWidth-1:0] dividend,
  input  logic [d64_pkg::FieldWidth-1:0] divisor,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [d64_pkg::FieldWidth-1:0] result,
  output logic                           divide_by_zero
);
  import d64_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int NS = W + 1;

  // Stage 0 holds magnitudes; stages 1..W hold partial results.
  logic [NS-1:0]  vld;
  logic [W-1:0]   rem  [NS];
  logic [W-1:0]   quo  [NS];
  logic [W-1:0]   dsr  [NS];
  logic [NS-1:0]  neg;
  logic [NS-1:0]  isrem;
  logic [NS-1:0]  dz;
  logic [NS:0]    adv;

  logic           ovld;
  logic [FieldWidth-1:0] ores;
  logic           odz;

  logic [W-1:0] n_in, d_in, n_mag, d_mag;
  logic         sn, sd, sgn;

  always_comb begin
    adv[NS] = !ovld || out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end
  assign ready = adv[0];

  assign n_in = dividend[W-1:0];
  assign d_in = divisor[W-1:0];
  assign sgn  = operation[1];
  assign sn   = sgn && n_in[W-1];
  assign sd   = sgn && d_in[W-1];
  assign n_mag = sn ? (~n_in + W'(1)) : n_in;
  assign d_mag = sd ? (~d_in + W'(1)) : d_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= valid;
    end
    if (adv[0]) begin
      rem[0]   <= '0;
      quo[0]   <= n_mag;
      dsr[0]   <= d_mag;
      neg[0]   <= sn ^ sd;
      isrem[0] <= (operation == OP_UREM);
      dz[0]    <= (d_in == '0);
    end
  end

  // Each step shifts one dividend bit into the partial remainder and tries
  // to subtract the divisor; the quotient bit replaces the consumed bit.
  for (genvar s = 1; s < NS; s++) begin : g_step
    logic [W:0] sh, diff;
    assign sh   = {rem[s-1], quo[s-1][W-1]};
    assign diff = sh - {1'b0, dsr[s-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv[s]) begin
        vld[s] <= vld[s-1];
      end
      if (adv[s]) begin
        if (!diff[W]) begin
          rem[s] <= diff[W-1:0];
          quo[s] <= {quo[s-1][W-2:0], 1'b1};
        end else begin
          rem[s] <= sh[W-1:0];
          quo[s] <= {quo[s-1][W-2:0], 1'b0};
        end
        dsr[s]   <= dsr[s-1];
        neg[s]   <= neg[s-1];
        isrem[s] <= isrem[s-1];
        dz[s]    <= dz[s-1];
      end
    end
  end

  logic [W-1:0] fin;
  always_comb begin
    if (dz[NS-1]) begin
      fin = '0;
    end else if (isrem[NS-1]) begin
      fin = rem[NS-1];
    end else if (neg[NS-1]) begin
      fin = ~quo[NS-1] + W'(1);
    end else begin
      fin = quo[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (adv[NS]) begin
      ovld <= vld[NS-1];
    end
    if (adv[NS]) begin
      ores <= FieldWidth'(fin);
      odz  <= dz[NS-1];
    end
  end

  assign out_valid      = ovld;
  assign result         = ores;
  assign divide_by_zero = odz;

`ifndef SYNTH
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result == '0)
    else $error("zero divisor gave a nonzero result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("stalled output word changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !ovld |-> ready)
    else $error("pipeline stalled with an empty output");
`endif
endmodule

/* bench/div64_checker.sv */
// Checker for the 64-bit integer divider: watches both channels, predicts
// each result from the accepted words and compares. Depends on d64_pkg.
`timescale 1ns / 1ps
module div64_checker #(
  parameter int DATA_WIDTH = d64_pkg::DefDataWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        ready,
  input  logic [1:0]  operation,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] result,
  input  logic        divide_by_zero,
  output int          fail_count,
  output int          pending
);
  import d64_pkg::*;

  typedef struct packed {
    logic [63:0] quotient_or_rem;
    logic        dbz;
  } div_answer_t;

  div_answer_t answers_due[$];

  function automatic logic [63:0] wmask();
    return {64{1'b1}} >> (64 - DATA_WIDTH);
  endfunction

  function automatic div_answer_t divide_word(logic [1:0] op, logic [63:0] n_in,
                                              logic [63:0] d_in);
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] d;
    logic        flip;
    div_answer_t a;
    m = wmask();
    n = n_in & m;
    d = d_in & m;
    flip = 1'b0;
    a.dbz = 1'b0;
    if (d == 0) begin
      a.quotient_or_rem = '0;
      a.dbz = 1'b1;
      return a;
    end
    // Operation 3 decodes by its high bit and acts as the signed quotient.
    if (op[1]) begin
      if (n[DATA_WIDTH-1]) begin
        n = (~n + 1) & m;
        flip = 1'b1;
      end
      if (d[DATA_WIDTH-1]) begin
        d = (~d + 1) & m;
        flip = !flip;
      end
      a.quotient_or_rem = n / d;
      if (flip) a.quotient_or_rem = (~a.quotient_or_rem + 1) & m;
    end else if (op == OP_UREM) begin
      a.quotient_or_rem = n % d;
    end else begin
      a.quotient_or_rem = n / d;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    div_answer_t e;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
      answers_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected word result=%h dbz=%b", $time, result, divide_by_zero);
          fail_count <= fail_count + 1;
        end else begin
          e = answers_due.pop_front();
          if (e.quotient_or_rem !== result || e.dbz !== divide_by_zero) begin
            $display("%0t: expected result=%h dbz=%b, actual result=%h dbz=%b", $time,
                     e.quotient_or_rem, e.dbz, result, divide_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (valid && ready) answers_due.push_back(divide_word(operation, dividend, divisor));
      pending <= answers_due.size();
    end
  end
endmodule

/* bench/tb_div64_signed_unsigned.sv */
// Testbench top for the 64-bit integer divider: drives directed and random
// words with random gaps and stalls, and gives the verdict. Depends on
// d64_pkg, div64_signed_unsigned and div64_checker.
`timescale 1ns / 1ps
module tb_div64_signed_unsigned;
  import d64_pkg::*;

  localparam int RandWords = 2000;
  localparam int IdleLimit = 20000;

  logic        clk;
  logic        rst;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] dividend;
  logic [63:0] divisor;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result;
  logic        divide_by_zero;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          long_hold;

  div64_signed_unsigned dut (.*);
  div64_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Valid stays high across back-to-back words; it drops only before a gap.
  task automatic send_word(logic [1:0] op, logic [63:0] n, logic [63:0] d);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1'b1;
    operation <= op;
    dividend <= n;
    divisor <= d;
    @(posedge clk);
    while (!ready) @(posedge clk);
  endtask

  // Pending is updated at the accepting edge, so drain waits for a clock edge before it reads it.
  task automatic drain();
    valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int shift;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 4))
      0: begin
        shift = $urandom_range(0, 63);
        v = v >> shift;
      end
      1: v = {64{v[63]}} ^ (v >> $urandom_range(32, 63));
      default: ;
    endcase
    return v;
  endfunction

  // Receiver: random stalls per word, one long hold-off to fill the pipeline.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("div64_signed_unsigned: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] min_neg;
    logic [1:0] op;
    rst = 1'b1;
    valid = 1'b0;
    operation = OP_UQUOT;
    dividend = '0;
    divisor = '0;
    long_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    min_neg = 64'h8000_0000_0000_0000;
    send_word(OP_UQUOT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
    send_word(OP_UQUOT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_UQUOT, 64'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_UQUOT, 64'd0, 64'd7);
    send_word(OP_UREM, 64'hFFFF_FFFF_FFFF_FFFF, 64'd10);
    send_word(OP_UREM, 64'd3, 64'h8000_0000_0000_0001);
    send_word(OP_SQUOT, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
    send_word(OP_SQUOT, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE);
    send_word(OP_SQUOT, 64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE);
    // Most negative value by minus one wraps back to itself.
    send_word(OP_SQUOT, min_neg, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_SQUOT, min_neg, min_neg);
    send_word(OP_SQUOT, 64'h7FFF_FFFF_FFFF_FFFF, min_neg);
    send_word(OP_SQUOT, min_neg, 64'd1);
    // Zero divisor on every operation, the unused code included.
    send_word(OP_UQUOT, 64'd123, 64'd0);
    send_word(OP_UREM, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_word(OP_SQUOT, min_neg, 64'd0);
    send_word(OP_UNUSED, 64'd9, 64'd0);
    send_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFF6, 64'd3);
    // Wait for the pipeline to drain, then fill it against a stalled receiver.
    drain();
    long_hold = 1'b1;
    for (int i = 0; i < RandWords; i++) begin
      op = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 40) == 0) send_word(op, rand_operand(), 64'd0);
      else send_word(op, rand_operand(), rand_operand() | 64'($urandom_range(0, 1)));
      if (i == RandWords / 2) drain();
    end
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("div64_signed_unsigned: match");
    else $display("div64_signed_unsigned: mismatch");
    $finish;
  end
endmodule
